[rtl/assert_macros.svh]
// assertion helpers for the pool
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock edge outside reset
`define ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// implication whose consequent is checked in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/sflp_pkg.sv]
package sflp_pkg;

  localparam logic [1:0] MODE_ADD    = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_GET    = 2'd2;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_NONE = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;

  localparam logic REG_LIMIT   = 1'b0;
  localparam logic REG_BUCKETS = 1'b1;

  localparam int ID_W     = 8;
  localparam int LIMIT_W  = 32;
  localparam int BCOUNT_W = 4;

  typedef enum logic [10:0] {
    S_IDLE    = 11'b00000000001,
    S_CLASS   = 11'b00000000010,
    S_RDSELF  = 11'b00000000100,
    S_CHKSELF = 11'b00000001000,
    S_ADDWR   = 11'b00000010000,
    S_UNLINK  = 11'b00000100000,
    S_BHEAD   = 11'b00001000000,
    S_WALKRD  = 11'b00010000000,
    S_WALKCHK = 11'b00100000000,
    S_FIXNB   = 11'b01000000000,
    S_OUT     = 11'b10000000000
  } state_t;

endpackage

[rtl/segregated_free_list_pool.sv]
// Segregated-fit free list allocator. Free descriptors sit in size-class bucket lists
// held in a descriptor memory with a registered read, driven by a small sequencer.
// A bad mode goes straight to the result; a bad add or remove is caught by its free
// flag before any list changes. An add classifies the size bucket by bucket, writes the
// entry at the head of its list and fixes the old head's back link if the list was not
// empty. A remove reads its entry, fixes the bucket head, unlinks it from its predecessor
// and fixes the successor if it has one. A get classifies the size, walks each list from
// that bucket on, and unlinks the first entry that fits or reports none.
// One request is handled at a time. A new request is taken while the previous result
// still waits; a finished result waits in the sequencer until the result register is
// free. No clearing pass after reset.
module segregated_free_list_pool #(
  parameter int NUM_DESCRIPTORS = 256,
  parameter int MAX_BUCKETS     = 8,
  parameter int SIZE_BITS       = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [sflp_pkg::LIMIT_W-1:0] cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  mode,
  input  logic [sflp_pkg::ID_W-1:0]   descriptor_id,
  input  logic [SIZE_BITS-1:0]        block_size,
  input  logic [SIZE_BITS-1:0]        wanted_size,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  status,
  output logic [sflp_pkg::ID_W-1:0]   granted_id,
  output logic [SIZE_BITS-1:0]        granted_size
);
  import sflp_pkg::*;
  `include "assert_macros.svh"

  localparam int AW = (NUM_DESCRIPTORS > 1) ? $clog2(NUM_DESCRIPTORS) : 1;
  localparam int PW = AW + 1;
  localparam int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam logic [PW-1:0] NULL_P = PW'(NUM_DESCRIPTORS);
  localparam logic [SIZE_BITS-1:0] SMAX = '1;
  localparam int CW = (PW > 17) ? PW : 17;

  // entry memory: size, next, prev in one word
  localparam int EW = SIZE_BITS + 2 * PW;
  logic [EW-1:0] mem [NUM_DESCRIPTORS];
  logic [EW-1:0] rdata;
  logic [AW-1:0] raddr, waddr;
  logic          we;
  logic [EW-1:0] wdata;
  logic [NUM_DESCRIPTORS-1:0] free_q;
  logic [PW-1:0] head [MAX_BUCKETS];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  logic [SIZE_BITS-1:0] limit;
  logic [BCOUNT_W-1:0]  bcount;
  always_ff @(posedge clk) begin
    if (rst) begin
      limit  <= SIZE_BITS'(16);
      bcount <= BCOUNT_W'(4);
    end else if (cfg_we) begin
      if (cfg_index == REG_LIMIT) limit <= SIZE_BITS'(cfg_data);
      else bcount <= cfg_data[BCOUNT_W-1:0];
    end
  end

  logic [BW:0] nb;
  always_comb begin
    if (bcount == '0) nb = (BW+1)'(1);
    else if ({1'b0, bcount} > (BCOUNT_W+1)'(MAX_BUCKETS)) nb = (BW+1)'(MAX_BUCKETS);
    else nb = (BW+1)'(bcount);
  end

  state_t state;
  logic [1:0] r_mode;
  logic [AW-1:0] r_id;
  logic [SIZE_BITS-1:0] r_size;
  logic [SIZE_BITS-1:0] lim;
  logic [BW:0] k;
  logic [PW-1:0] cur, u_prev, u_next;
  logic [CW-1:0] steps;
  logic [1:0] o_status;
  logic [ID_W-1:0] g_id;
  logic [SIZE_BITS-1:0] g_size;

  wire sel_bad = (r_mode == MODE_ADD && free_q[r_id]) ||
                 (r_mode == MODE_REMOVE && !free_q[r_id]);
  wire accept = in_valid && !in_stall;
  wire out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);
  wire [SIZE_BITS-1:0] e_size = rdata[EW-1 -: SIZE_BITS];
  wire [PW-1:0] e_next = rdata[2*PW-1 -: PW];
  wire [PW-1:0] e_prev = rdata[PW-1:0];
  wire [SIZE_BITS-1:0] lim_dbl = (lim > (SMAX >> 1)) ? SMAX : {lim[SIZE_BITS-2:0], 1'b0};
  wire id_ok = ({{(32-ID_W){1'b0}}, descriptor_id} < 32'(NUM_DESCRIPTORS));

  always_comb begin
    raddr = r_id;
    we = 1'b0; waddr = r_id; wdata = '0;
    unique case (state)
      S_WALKRD:  raddr = cur[AW-1:0];
      S_ADDWR: begin
        we = 1'b1; waddr = r_id;
        wdata = {r_size, head[k[BW-1:0]], NULL_P};
      end
      S_UNLINK: begin
        if (u_prev != NULL_P) begin
          we = 1'b1; waddr = u_prev[AW-1:0];
          wdata = {rdata[EW-1 -: SIZE_BITS], u_next, rdata[PW-1:0]};
        end
      end
      S_FIXNB: begin
        we = 1'b1; waddr = u_next[AW-1:0];
        wdata = {rdata[EW-1 -: SIZE_BITS], rdata[2*PW-1 -: PW], u_prev};
      end
      S_BHEAD:   raddr = u_prev[AW-1:0];
      S_CHKSELF: raddr = e_prev[AW-1:0];
      default: ;
    endcase
    if (state == S_ADDWR) raddr = head[k[BW-1:0]][AW-1:0];
    if (state == S_UNLINK) raddr = u_next[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      free_q <= '0;
      for (int b = 0; b < MAX_BUCKETS; b++) head[b] <= NULL_P;
    end else begin
      if (state == S_OUT && out_free) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (accept) begin
          r_mode <= mode;
          r_id <= AW'(descriptor_id);
          r_size <= (mode == MODE_GET) ? wanted_size : block_size;
          lim <= limit;
          k <= '0;
          g_id <= '0;
          g_size <= '0;
          if ((mode == MODE_ADD || mode == MODE_REMOVE) && id_ok) begin
            state <= (mode == MODE_ADD) ? S_CLASS : S_RDSELF;
          end else if (mode == MODE_GET) begin
            state <= S_CLASS;
          end else begin
            o_status <= ST_BAD;
            state <= S_OUT;
          end
        end
        S_CLASS: begin
          // one bucket step per cycle
          if (r_mode == MODE_ADD && free_q[r_id]) begin
            o_status <= ST_BAD; state <= S_OUT;
          end else if (k + 1'b1 < nb && r_size > lim) begin
            lim <= lim_dbl; k <= k + 1'b1;
          end else if (r_mode == MODE_ADD) begin
            state <= S_ADDWR;
          end else begin
            cur <= head[k[BW-1:0]]; steps <= '0; state <= S_WALKRD;
          end
        end
        S_ADDWR: begin
          u_next <= head[k[BW-1:0]];
          u_prev <= {1'b0, r_id};
          head[k[BW-1:0]] <= {1'b0, r_id};
          free_q[r_id] <= 1'b1;
          o_status <= ST_DONE;
          state <= (head[k[BW-1:0]] != NULL_P) ? S_FIXNB : S_OUT;
        end
        S_RDSELF: begin
          if (sel_bad) begin
            o_status <= ST_BAD; state <= S_OUT;
          end else state <= S_CHKSELF;
        end
        S_CHKSELF: begin
          u_prev <= e_prev; u_next <= e_next;
          state <= S_BHEAD;
        end
        S_BHEAD: begin
          // prev entry read is in flight; fix bucket heads
          if (u_prev == NULL_P)
            for (int b = 0; b < MAX_BUCKETS; b++)
              if (head[b] == {1'b0, r_id}) head[b] <= u_next;
          state <= S_UNLINK;
        end
        S_UNLINK: begin
          free_q[r_id] <= 1'b0;
          o_status <= ST_DONE;
          state <= (u_next != NULL_P) ? S_FIXNB : S_OUT;
        end
        S_FIXNB: state <= S_OUT;
        S_WALKRD: begin
          if (cur == NULL_P || steps >= CW'(NUM_DESCRIPTORS)) begin
            if (k + 1'b1 < nb) begin
              k <= k + 1'b1; cur <= head[k[BW-1:0] + 1'b1]; steps <= '0;
            end else begin
              o_status <= ST_NONE; state <= S_OUT;
            end
          end else state <= S_WALKCHK;
        end
        S_WALKCHK: begin
          if (e_size >= r_size) begin
            r_id <= cur[AW-1:0];
            g_id <= ID_W'(cur);
            g_size <= e_size;
            u_prev <= e_prev; u_next <= e_next;
            state <= S_BHEAD;
          end else begin
            cur <= e_next; steps <= steps + 1'b1; state <= S_WALKRD;
          end
        end
        S_OUT: begin
          // hold the finished request until the result register is free
          if (out_free) begin
            status <= o_status;
            granted_id <= g_id;
            granted_size <= g_size;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_IMP(a_stall_busy, clk, rst, state != S_IDLE, in_stall)
  `ASSERT_NEXT(a_fin_valid, clk, rst, state == S_OUT, out_valid)
  `ASSERT_IMP(a_grant_status, clk, rst, out_valid && granted_size != '0, status == ST_DONE)
endmodule
